@@ rtl/lrupr_pkg.sv @@
// Shared types, constants and the page wrap table for the LRU page replacement block.
package lrupr_pkg;

	localparam int FRAMES_DEF = 8;
	localparam int PAGES      = 256;
	localparam int PAGE_W     = 8;
	localparam int CFG_W      = 4;
	localparam int SLOT_W     = 3;
	localparam int COUNT_W    = 32;
	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);

	typedef logic [PAGE_W-1:0] page_t;
	typedef logic [(1 << PAGE_W)-1:0][PAGE_W-1:0] page_tbl_t;

	typedef struct packed {
		logic               fault;
		logic [SLOT_W-1:0]  slot;
		logic               evicted_valid;
		page_t              evicted_page;
		logic [COUNT_W-1:0] fault_count;
	} res_t;

	function automatic page_tbl_t build_page_wrap();
		page_tbl_t t;
		int        r;
		r = 0;
		for (int v = 0; v < (1 << PAGE_W); v++) begin
			t[v] = PAGE_W'(r);
			r++;
			if (r == PAGES) begin
				r = 0;
			end
		end
		return t;
	endfunction

	localparam page_tbl_t PAGE_WRAP = build_page_wrap();

endpackage

@@ rtl/lru_page_replacement.sv @@
// Top level of the LRU page replacement block: input register, frame store and result register.
// A transaction passes through the input register and then the result register.
// Throughput: one transaction per cycle while out_stall does not hold the result; the frame
// lookup, victim choice and rank update are all combinational between the two registers.
// Reset clears the frame ranks, fill count, fault counter and handshake state, and sets
// frames_in_use to 8; frame pages are held but never read before they are filled.
module lru_page_replacement #(
	parameter int FRAMES = lrupr_pkg::FRAMES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wen,
	input  logic [lrupr_pkg::CFG_W-1:0]   cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  lrupr_pkg::page_t              page,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          fault,
	output logic [lrupr_pkg::SLOT_W-1:0]  slot,
	output logic                          evicted_valid,
	output lrupr_pkg::page_t              evicted_page,
	output logic [lrupr_pkg::COUNT_W-1:0] fault_count
);

	logic [lrupr_pkg::CFG_W-1:0] frames_in_use_q;
	logic                        valid_s1;
	lrupr_pkg::page_t            page_s1;
	logic                        out_valid_q;
	lrupr_pkg::res_t             res_q;
	lrupr_pkg::res_t             res;
	logic                        out_free;
	logic                        go;

	assign out_free = !out_valid_q || !out_stall;
	assign go       = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_in_use_q <= lrupr_pkg::CFG_RESET;
		end else if (cfg_wen) begin
			frames_in_use_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (out_free) begin
				out_valid_q <= go;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			page_s1 <= lrupr_pkg::PAGE_WRAP[page];
		end
		if (go) begin
			res_q <= res;
		end
	end

	lrupr_frames #(
		.FRAMES (FRAMES)
	) u_frames (
		.clk           (clk),
		.arst_n        (arst_n),
		.go            (go),
		.pg            (page_s1),
		.frames_in_use (frames_in_use_q),
		.res           (res)
	);

	assign out_valid     = out_valid_q;
	assign fault         = res_q.fault;
	assign slot          = res_q.slot;
	assign evicted_valid = res_q.evicted_valid;
	assign evicted_page  = res_q.evicted_page;
	assign fault_count   = res_q.fault_count;

endmodule

@@ rtl/lrupr_frames.sv @@
// Frame store with recency ranks: parallel lookup, fill or eviction choice and rank update.
module lrupr_frames #(
	parameter int FRAMES = lrupr_pkg::FRAMES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        go,
	input  lrupr_pkg::page_t            pg,
	input  logic [lrupr_pkg::CFG_W-1:0] frames_in_use,
	output lrupr_pkg::res_t             res
);

	localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int FILL_W = $clog2(FRAMES + 1);

	lrupr_pkg::page_t   frame_page_q [FRAMES];
	logic [IDX_W-1:0]   frame_rank_q [FRAMES];
	logic [FILL_W-1:0]  filled_q;
	logic [lrupr_pkg::COUNT_W-1:0] faults_q;

	logic [FILL_W-1:0]  n;
	logic [FRAMES-1:0]  active;
	logic [FRAMES-1:0]  filled;
	logic [FRAMES-1:0]  match;
	logic [FRAMES-1:0]  hit_oh;
	logic [FRAMES-1:0]  fill_oh;
	logic [FRAMES-1:0]  oldest_oh;
	logic [FRAMES-1:0]  sel_oh;
	logic               hit;
	logic               fill;
	logic               evict;
	logic [IDX_W-1:0]   sel_idx;
	logic [IDX_W-1:0]   sel_rank;
	lrupr_pkg::page_t   sel_page;
	logic [lrupr_pkg::COUNT_W-1:0] faults_nxt;

	always_comb begin
		if (frames_in_use == '0) begin
			n = FILL_W'(1);
		end else if (int'(frames_in_use) > FRAMES) begin
			n = FILL_W'(FRAMES);
		end else begin
			n = FILL_W'(frames_in_use);
		end
	end

	always_comb begin
		for (int i = 0; i < FRAMES; i++) begin
			active[i]  = FILL_W'(i) < n;
			filled[i]  = FILL_W'(i) < filled_q;
			match[i]   = active[i] && filled[i] && (frame_page_q[i] == pg);
			fill_oh[i] = FILL_W'(i) == filled_q;
			oldest_oh[i] = active[i];
			for (int j = 0; j < FRAMES; j++) begin
				if ((j != i) && active[j] && !(frame_rank_q[j] < frame_rank_q[i])) begin
					oldest_oh[i] = 1'b0;
				end
			end
		end
	end

	assign hit    = |match;
	assign hit_oh = match & (~match + FRAMES'(1));
	assign fill   = !hit && (filled_q < n);
	assign evict  = !hit && !fill;
	assign sel_oh = hit ? hit_oh : (fill ? fill_oh : oldest_oh);

	always_comb begin
		sel_idx  = '0;
		sel_rank = '0;
		sel_page = '0;
		for (int i = 0; i < FRAMES; i++) begin
			if (sel_oh[i]) begin
				sel_idx  = sel_idx | IDX_W'(i);
				sel_rank = sel_rank | frame_rank_q[i];
				sel_page = sel_page | frame_page_q[i];
			end
		end
	end

	assign faults_nxt = (!hit && (faults_q != '1)) ? faults_q + 1'b1 : faults_q;

	always_comb begin
		res.fault         = !hit;
		res.slot          = lrupr_pkg::SLOT_W'(sel_idx);
		res.evicted_valid = evict;
		res.evicted_page  = evict ? sel_page : '0;
		res.fault_count   = faults_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q <= '0;
			faults_q <= '0;
			for (int i = 0; i < FRAMES; i++) begin
				frame_rank_q[i] <= '0;
			end
		end else if (go) begin
			faults_q <= faults_nxt;
			if (fill) begin
				filled_q <= filled_q + 1'b1;
			end
			for (int i = 0; i < FRAMES; i++) begin
				if (sel_oh[i]) begin
					frame_rank_q[i] <= '0;
				end else if (filled[i] && (fill || (frame_rank_q[i] < sel_rank))) begin
					frame_rank_q[i] <= frame_rank_q[i] + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < FRAMES; i++) begin
			if (go && !hit && sel_oh[i]) begin
				frame_page_q[i] <= pg;
			end
		end
	end

endmodule
